>>> design/mie_pkg.sv
// package for the mips instruction executor: constants, codes and types
`default_nettype none
package mie_pkg;
  localparam int unsigned MemBytes = 65536;
  localparam int unsigned MemWords = MemBytes / 4;
  localparam int unsigned WordAw = $clog2(MemWords);
  localparam logic [31:0] ResetPc = 32'h0000_0000;
  localparam logic [31:0] MemBytesW = 32'(MemBytes);

  localparam logic [5:0] OpSpecial = 6'h00;
  localparam logic [5:0] OpJ = 6'h02;
  localparam logic [5:0] OpJal = 6'h03;
  localparam logic [5:0] OpBeq = 6'h04;
  localparam logic [5:0] OpBne = 6'h05;
  localparam logic [5:0] OpAddiu = 6'h09;
  localparam logic [5:0] OpSlti = 6'h0a;
  localparam logic [5:0] OpSltiu = 6'h0b;
  localparam logic [5:0] OpAndi = 6'h0c;
  localparam logic [5:0] OpOri = 6'h0d;
  localparam logic [5:0] OpXori = 6'h0e;
  localparam logic [5:0] OpLui = 6'h0f;
  localparam logic [5:0] OpLb = 6'h20;
  localparam logic [5:0] OpLh = 6'h21;
  localparam logic [5:0] OpLw = 6'h23;
  localparam logic [5:0] OpLbu = 6'h24;
  localparam logic [5:0] OpLhu = 6'h25;
  localparam logic [5:0] OpSb = 6'h28;
  localparam logic [5:0] OpSh = 6'h29;
  localparam logic [5:0] OpSw = 6'h2b;

  localparam logic [5:0] FnSll = 6'h00;
  localparam logic [5:0] FnSrl = 6'h02;
  localparam logic [5:0] FnSra = 6'h03;
  localparam logic [5:0] FnJr = 6'h08;
  localparam logic [5:0] FnJalr = 6'h09;
  localparam logic [5:0] FnSyscall = 6'h0c;
  localparam logic [5:0] FnMfhi = 6'h10;
  localparam logic [5:0] FnMflo = 6'h12;
  localparam logic [5:0] FnMult = 6'h18;
  localparam logic [5:0] FnMultu = 6'h19;
  localparam logic [5:0] FnAddu = 6'h21;
  localparam logic [5:0] FnSubu = 6'h23;
  localparam logic [5:0] FnAnd = 6'h24;
  localparam logic [5:0] FnOr = 6'h25;
  localparam logic [5:0] FnXor = 6'h26;
  localparam logic [5:0] FnNor = 6'h27;
  localparam logic [5:0] FnSlt = 6'h2a;
  localparam logic [5:0] FnSltu = 6'h2b;

  typedef enum logic [1:0] {
    StOk = 2'd0, StIllegal = 2'd1, StBadAddr = 2'd2, StSyscall = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SzByte = 2'd0, SzHalf = 2'd1, SzWord = 2'd2
  } size_e;

  typedef enum logic [1:0] {
    PhIdle = 2'd0, PhExec = 2'd1, PhClear = 2'd2
  } phase_e;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [31:0] mem_address;
    logic [31:0] mem_value;
    logic [1:0]  mem_size;
    logic [1:0]  status;
  } result_t;
endpackage
`default_nettype wire

>>> design/mie_mult.sv
// multiplier for mult and multu: four registered 16x16 partial products, summed combinationally
`default_nettype none
module mie_mult (
  input  wire logic        clk_i,
  input  wire logic        start_i,
  input  wire logic        signed_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);
  logic [31:0] ll_q, lh_q, hl_q, hh_q;
  logic        neg_a_q, neg_b_q, done_q;
  logic [31:0] a_q, b_q;
  logic [63:0] raw;

  always_ff @(posedge clk_i) begin
    ll_q    <= a_i[15:0] * b_i[15:0];
    lh_q    <= a_i[15:0] * b_i[31:16];
    hl_q    <= a_i[31:16] * b_i[15:0];
    hh_q    <= a_i[31:16] * b_i[31:16];
    neg_a_q <= signed_i & a_i[31];
    neg_b_q <= signed_i & b_i[31];
    a_q     <= a_i;
    b_q     <= b_i;
    done_q  <= start_i;
  end

  // signed correction: subtract the other operand shifted up for each negative one
  always_comb begin
    raw = {32'd0, ll_q} + {16'd0, lh_q, 16'd0} + {16'd0, hl_q, 16'd0} + {hh_q, 32'd0};
    prod_o = raw - {(neg_a_q ? b_q : 32'd0), 32'd0} - {(neg_b_q ? a_q : 32'd0), 32'd0};
  end

  assign done_o = done_q;
endmodule
`default_nettype wire

>>> design/mips_instruction_executor.sv
// top level: mips32 instruction executor with register file and data memory rams
//
// usage: one 32-bit instruction word enters on instr_word_i per request
// (instr_valid_i high, instr_stall_o low). each request gives exactly one
// result on the result ports, held while res_valid_o is high and res_stall_i
// is high.
// the register file is a synchronous ram read as a request is accepted; the
// word memory is read into dm_rd_q before rd_ok_q lets the request retire,
// and both are written back as it retires.
// mult/multu use a pipelined multiplier; hi/lo are written the cycle after
// the multiply retires, before an mfhi/mflo right behind it reads them, so
// there is no extra stall.
// the next request is accepted at the edge where the current one retires,
// with the retiring register write bypassed to its operand reads; a full
// result register that is stalled holds the current request and the input.
// reset: pc, hi, lo and the register file valid bits clear at once; the data
// memory is swept to zero one word a cycle, all MemWords (16384) words, after
// reset, with instr_stall_o high throughout.
// a result stall leaves everything held; no request is lost.
`default_nettype none
module mips_instruction_executor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        instr_valid_i,
  output logic             instr_stall_o,
  input  wire logic [31:0] instr_word_i,
  output logic             res_valid_o,
  input  wire logic        res_stall_i,
  output logic [31:0]      next_pc_o,
  output logic             reg_written_o,
  output logic [4:0]       reg_index_o,
  output logic [31:0]      reg_value_o,
  output logic             mem_written_o,
  output logic [31:0]      mem_address_o,
  output logic [31:0]      mem_value_o,
  output logic [1:0]       mem_size_o,
  output logic [1:0]       status_o
);
  localparam int unsigned Aw = mie_pkg::WordAw;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid_q;
  logic [31:0] dm_mem [mie_pkg::MemWords];

  mie_pkg::phase_e phase_q, phase_d;
  logic [Aw:0]     clr_q, clr_d;
  logic [31:0]     pc_q, pc_d, hi_q, lo_q;
  logic [31:0]     ir_q;
  logic [31:0]     rs_raw_q, rt_raw_q, dm_rd_q;
  logic            mul_busy_q;
  logic            mul_signed;
  logic            res_full_q;
  logic            rd_ok_q;
  mie_pkg::result_t res_q, res_d;

  logic            accept, exec_go, fire;
  logic [31:0]     a, b, se, pc4, addr, wval, mval, v, ldv;
  logic [5:0]      op, fn;
  logic [4:0]      rs, rt, rd, sh, widx;
  logic            wr, st, mem_op, is_store, sign_ld, mul_go, hazard;
  logic [1:0]      status, msize;
  logic [31:0]     nbytes;
  logic [32:0]     endaddr;
  logic            bad;
  logic [3:0]      be;
  logic [31:0]     wdata;
  logic [Aw-1:0]   dm_waddr, dm_raddr;
  logic            dm_we;
  logic [63:0]     prod;
  logic            mul_done;

  assign op = ir_q[31:26];
  assign rs = ir_q[25:21];
  assign rt = ir_q[20:16];
  assign rd = ir_q[15:11];
  assign sh = ir_q[10:6];
  assign fn = ir_q[5:0];

  // mfhi/mflo right after a multiply must wait for hi/lo
  assign hazard = mul_busy_q && (op == mie_pkg::OpSpecial) &&
                  (fn == mie_pkg::FnMfhi || fn == mie_pkg::FnMflo);
  assign exec_go  = (phase_q == mie_pkg::PhExec) && !hazard && !(res_full_q && res_stall_i);
  assign fire = exec_go && rd_ok_q;
  assign instr_stall_o = !((phase_q == mie_pkg::PhIdle) ||
                           ((phase_q == mie_pkg::PhExec) && fire));
  assign accept = instr_valid_i && !instr_stall_o;

  // register file read ports, addressed by the incoming request;
  // bypass the write-back of the retiring request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (fire && res_d.reg_written && res_d.reg_index == instr_word_i[25:21]) begin
        rs_raw_q <= res_d.reg_value;
      end else begin
        rs_raw_q <= rf_mem[instr_word_i[25:21]];
      end
      if (fire && res_d.reg_written && res_d.reg_index == instr_word_i[20:16]) begin
        rt_raw_q <= res_d.reg_value;
      end else begin
        rt_raw_q <= rf_mem[instr_word_i[20:16]];
      end
      ir_q     <= instr_word_i;
    end
  end

  always_comb begin
    se = {{16{ir_q[15]}}, ir_q[15:0]};
    a = rf_valid_q[rs] ? rs_raw_q : 32'd0;
    b = rf_valid_q[rt] ? rt_raw_q : 32'd0;
  end

  // the data word is read in the cycle after accept using the forwarded rs value;
  // the address is formed combinationally here; the word is registered into dm_rd_q below
  always_comb begin
    pc4 = pc_q + 32'd4;
    addr = a + se;
    dm_raddr = addr[Aw+1:2];
  end

  always_comb begin
    wr = 1'b0; st = 1'b0; widx = 5'd0; wval = 32'd0;
    mem_op = 1'b0; is_store = 1'b0; sign_ld = 1'b0; msize = mie_pkg::SzByte;
    status = mie_pkg::StOk; pc_d = pc4; mul_go = 1'b0; mul_signed = 1'b0;
    if (op == mie_pkg::OpSpecial) begin
      case (fn)
        mie_pkg::FnSll: begin wr = 1'b1; widx = rd; wval = b << sh; end
        mie_pkg::FnSrl: begin wr = 1'b1; widx = rd; wval = b >> sh; end
        mie_pkg::FnSra: begin wr = 1'b1; widx = rd; wval = 32'($signed(b) >>> sh); end
        mie_pkg::FnJr: pc_d = a;
        mie_pkg::FnJalr: begin pc_d = a; wr = 1'b1; widx = rd; wval = pc4; end
        mie_pkg::FnSyscall: status = mie_pkg::StSyscall;
        mie_pkg::FnMfhi: begin wr = 1'b1; widx = rd; wval = hi_q; end
        mie_pkg::FnMflo: begin wr = 1'b1; widx = rd; wval = lo_q; end
        mie_pkg::FnMult: begin mul_go = 1'b1; mul_signed = 1'b1; end
        mie_pkg::FnMultu: mul_go = 1'b1;
        mie_pkg::FnAddu: begin wr = 1'b1; widx = rd; wval = a + b; end
        mie_pkg::FnSubu: begin wr = 1'b1; widx = rd; wval = a - b; end
        mie_pkg::FnAnd: begin wr = 1'b1; widx = rd; wval = a & b; end
        mie_pkg::FnOr: begin wr = 1'b1; widx = rd; wval = a | b; end
        mie_pkg::FnXor: begin wr = 1'b1; widx = rd; wval = a ^ b; end
        mie_pkg::FnNor: begin wr = 1'b1; widx = rd; wval = ~(a | b); end
        mie_pkg::FnSlt: begin
          wr = 1'b1; widx = rd; wval = {31'd0, $signed(a) < $signed(b)};
        end
        mie_pkg::FnSltu: begin wr = 1'b1; widx = rd; wval = {31'd0, a < b}; end
        default: status = mie_pkg::StIllegal;
      endcase
    end else begin
      case (op)
        mie_pkg::OpJ: pc_d = {pc4[31:28], ir_q[25:0], 2'b00};
        mie_pkg::OpJal: begin
          pc_d = {pc4[31:28], ir_q[25:0], 2'b00};
          wr = 1'b1; widx = 5'd31; wval = pc4;
        end
        mie_pkg::OpBeq: if (a == b) pc_d = pc4 + {se[29:0], 2'b00};
        mie_pkg::OpBne: if (a != b) pc_d = pc4 + {se[29:0], 2'b00};
        mie_pkg::OpAddiu: begin wr = 1'b1; widx = rt; wval = a + se; end
        mie_pkg::OpSlti: begin
          wr = 1'b1; widx = rt; wval = {31'd0, $signed(a) < $signed(se)};
        end
        mie_pkg::OpSltiu: begin wr = 1'b1; widx = rt; wval = {31'd0, a < se}; end
        mie_pkg::OpAndi: begin wr = 1'b1; widx = rt; wval = a & {16'd0, ir_q[15:0]}; end
        mie_pkg::OpOri: begin wr = 1'b1; widx = rt; wval = a | {16'd0, ir_q[15:0]}; end
        mie_pkg::OpXori: begin wr = 1'b1; widx = rt; wval = a ^ {16'd0, ir_q[15:0]}; end
        mie_pkg::OpLui: begin wr = 1'b1; widx = rt; wval = {ir_q[15:0], 16'd0}; end
        mie_pkg::OpLb: begin mem_op = 1'b1; msize = mie_pkg::SzByte; sign_ld = 1'b1; end
        mie_pkg::OpLh: begin mem_op = 1'b1; msize = mie_pkg::SzHalf; sign_ld = 1'b1; end
        mie_pkg::OpLw: begin mem_op = 1'b1; msize = mie_pkg::SzWord; end
        mie_pkg::OpLbu: begin mem_op = 1'b1; msize = mie_pkg::SzByte; end
        mie_pkg::OpLhu: begin mem_op = 1'b1; msize = mie_pkg::SzHalf; end
        mie_pkg::OpSb: begin mem_op = 1'b1; msize = mie_pkg::SzByte; is_store = 1'b1; end
        mie_pkg::OpSh: begin mem_op = 1'b1; msize = mie_pkg::SzHalf; is_store = 1'b1; end
        mie_pkg::OpSw: begin mem_op = 1'b1; msize = mie_pkg::SzWord; is_store = 1'b1; end
        default: status = mie_pkg::StIllegal;
      endcase
    end

    case (msize)
      mie_pkg::SzByte: begin nbytes = 32'd1; mval = {24'd0, b[7:0]}; end
      mie_pkg::SzHalf: begin nbytes = 32'd2; mval = {16'd0, b[15:0]}; end
      default: begin nbytes = 32'd4; mval = b; end
    endcase
    if (!is_store) mval = 32'd0;
    endaddr = {1'b0, addr} + {1'b0, nbytes};
    bad = (addr == 32'd0) || ((addr & (nbytes - 32'd1)) != 32'd0) ||
          (endaddr > {1'b0, mie_pkg::MemBytesW});

    v = dm_rd_q >> {addr[1:0], 3'b000};
    case (msize)
      mie_pkg::SzByte: ldv = {{24{sign_ld & v[7]}}, v[7:0]};
      mie_pkg::SzHalf: ldv = {{16{sign_ld & v[15]}}, v[15:0]};
      default: ldv = v;
    endcase

    if (mem_op) begin
      if (bad) status = mie_pkg::StBadAddr;
      else if (is_store) st = 1'b1;
      else begin wr = 1'b1; widx = rt; wval = ldv; end
    end

    res_d.next_pc     = pc_d;
    res_d.reg_written = wr;
    res_d.reg_index   = widx;
    res_d.reg_value   = wval;
    res_d.mem_written = st;
    res_d.mem_address = mem_op ? addr : 32'd0;
    res_d.mem_value   = mval;
    res_d.mem_size    = mem_op ? msize : 2'd0;
    res_d.status      = status;
    if (status == mie_pkg::StIllegal) begin
      res_d.next_pc = pc_q; res_d.reg_written = 1'b0; res_d.mem_written = 1'b0;
      res_d.mem_address = 32'd0; res_d.mem_value = 32'd0; res_d.mem_size = 2'd0;
    end else if (status == mie_pkg::StBadAddr) begin
      res_d.next_pc = pc_q; res_d.reg_written = 1'b0;
    end
    if (!res_d.reg_written || res_d.reg_index == 5'd0) begin
      res_d.reg_written = 1'b0; res_d.reg_index = 5'd0; res_d.reg_value = 32'd0;
    end
  end

  // data memory: one word read port, one word write port with byte enables, shared with the reset clear
  always_comb begin
    be = 4'b0000;
    case (msize)
      mie_pkg::SzByte: be = 4'b0001 << addr[1:0];
      mie_pkg::SzHalf: be = 4'b0011 << addr[1:0];
      default: be = 4'b1111;
    endcase
    wdata = b << {addr[1:0], 3'b000};
    if (phase_q == mie_pkg::PhClear) begin
      dm_we = 1'b1; be = 4'b1111; wdata = 32'd0; dm_waddr = clr_q[Aw-1:0];
    end else begin
      dm_we = fire && res_d.mem_written; dm_waddr = addr[Aw+1:2];
    end
  end

  // the read is issued every cycle at the combinational address; ir_q
  // and rs are already valid while phase is exec, so the read is repeated
  // each exec cycle and the result used once it has settled (see rd_ok_q)
  always_ff @(posedge clk_i) begin
    dm_rd_q <= dm_mem[dm_raddr];
    if (dm_we) begin
      for (int i = 0; i < 4; i++) begin
        if (be[i]) dm_mem[dm_waddr][8*i +: 8] <= wdata[8*i +: 8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_d.reg_written) rf_mem[res_d.reg_index] <= res_d.reg_value;
  end

  mie_mult u_mult (
    .clk_i   (clk_i),
    .start_i (fire && mul_go && status == mie_pkg::StOk),
    .signed_i(mul_signed),
    .a_i     (a),
    .b_i     (b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // phase control
  always_comb begin
    phase_d = phase_q;
    clr_d   = clr_q;
    case (phase_q)
      mie_pkg::PhClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (Aw+1)'(mie_pkg::MemWords - 1)) phase_d = mie_pkg::PhIdle;
      end
      mie_pkg::PhIdle: if (accept) phase_d = mie_pkg::PhExec;
      mie_pkg::PhExec: begin
        if (exec_go && rd_ok_q) phase_d = accept ? mie_pkg::PhExec : mie_pkg::PhIdle;
      end
      default: phase_d = mie_pkg::PhIdle;
    endcase
  end

  // a fresh request fetches its memory word into dm_rd_q before rd_ok_q lets it retire
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else if (accept) begin
      rd_ok_q <= 1'b0;
    end else if (phase_q == mie_pkg::PhExec) begin
      rd_ok_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mie_pkg::PhClear;
      clr_q      <= '0;
      pc_q       <= mie_pkg::ResetPc;
      hi_q       <= 32'd0;
      lo_q       <= 32'd0;
      rf_valid_q <= 32'd0;
      mul_busy_q <= 1'b0;
      res_full_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      clr_q      <= clr_d;
      mul_busy_q <= fire && mul_go && status == mie_pkg::StOk;
      if (mul_done) begin
        hi_q <= prod[63:32];
        lo_q <= prod[31:0];
      end
      if (fire) begin
        if (res_d.status == mie_pkg::StOk || res_d.status == mie_pkg::StSyscall) begin
          pc_q <= res_d.next_pc;
        end
        if (res_d.reg_written) rf_valid_q[res_d.reg_index] <= 1'b1;
        res_full_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  assign res_valid_o   = res_full_q;
  assign next_pc_o     = res_q.next_pc;
  assign reg_written_o = res_q.reg_written;
  assign reg_index_o   = res_q.reg_index;
  assign reg_value_o   = res_q.reg_value;
  assign mem_written_o = res_q.mem_written;
  assign mem_address_o = res_q.mem_address;
  assign mem_value_o   = res_q.mem_value;
  assign mem_size_o    = res_q.mem_size;
  assign status_o      = res_q.status;
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// testbench for the mips instruction executor: random and directed instruction streams
`timescale 1ns / 1ps
`default_nettype none

class mips_scoreboard;
  logic [31:0] pc;
  logic [31:0] regs [32];
  logic [31:0] hi;
  logic [31:0] lo;
  logic [7:0]  mem [int unsigned];
  mie_pkg::result_t pending [$];
  int errors;

  function new();
    pc = mie_pkg::ResetPc;
    foreach (regs[i]) regs[i] = '0;
    hi = '0;
    lo = '0;
    errors = 0;
  endfunction

  function logic [7:0] rd_byte(logic [31:0] a);
    if (mem.exists(a)) return mem[a];
    return 8'h00;
  endfunction

  function void note_request(logic [31:0] w);
    mie_pkg::result_t r;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh;
    logic [31:0] a, b, pc4, se, zi, v, mask;
    logic [63:0] p;
    logic mem_op, is_store, sign_ld, wr;
    int n;
    op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
    sh = w[10:6]; fn = w[5:0];
    a = regs[rs]; b = regs[rt]; pc4 = pc + 32'd4;
    se = {{16{w[15]}}, w[15:0]}; zi = {16'h0, w[15:0]};
    r = '0; r.next_pc = pc4; r.status = mie_pkg::StOk;
    mem_op = 0; is_store = 0; sign_ld = 0; wr = 0; n = 1;
    if (op == mie_pkg::OpSpecial) begin
      case (fn)
        mie_pkg::FnSll: begin wr = 1; r.reg_index = rd; r.reg_value = b << sh; end
        mie_pkg::FnSrl: begin wr = 1; r.reg_index = rd; r.reg_value = b >> sh; end
        mie_pkg::FnSra: begin wr = 1; r.reg_index = rd; r.reg_value = $signed(b) >>> sh; end
        mie_pkg::FnJr: r.next_pc = a;
        mie_pkg::FnJalr: begin
          r.next_pc = a; wr = 1; r.reg_index = rd; r.reg_value = pc4;
        end
        mie_pkg::FnSyscall: r.status = mie_pkg::StSyscall;
        mie_pkg::FnMfhi: begin wr = 1; r.reg_index = rd; r.reg_value = hi; end
        mie_pkg::FnMflo: begin wr = 1; r.reg_index = rd; r.reg_value = lo; end
        mie_pkg::FnMult: begin
          p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          hi = p[63:32]; lo = p[31:0];
        end
        mie_pkg::FnMultu: begin
          p = {32'h0, a} * {32'h0, b}; hi = p[63:32]; lo = p[31:0];
        end
        mie_pkg::FnAddu: begin wr = 1; r.reg_index = rd; r.reg_value = a + b; end
        mie_pkg::FnSubu: begin wr = 1; r.reg_index = rd; r.reg_value = a - b; end
        mie_pkg::FnAnd: begin wr = 1; r.reg_index = rd; r.reg_value = a & b; end
        mie_pkg::FnOr: begin wr = 1; r.reg_index = rd; r.reg_value = a | b; end
        mie_pkg::FnXor: begin wr = 1; r.reg_index = rd; r.reg_value = a ^ b; end
        mie_pkg::FnNor: begin wr = 1; r.reg_index = rd; r.reg_value = ~(a | b); end
        mie_pkg::FnSlt: begin
          wr = 1; r.reg_index = rd; r.reg_value = {31'h0, $signed(a) < $signed(b)};
        end
        mie_pkg::FnSltu: begin wr = 1; r.reg_index = rd; r.reg_value = {31'h0, a < b}; end
        default: r.status = mie_pkg::StIllegal;
      endcase
    end else begin
      case (op)
        mie_pkg::OpJ: r.next_pc = {pc4[31:28], w[25:0], 2'b00};
        mie_pkg::OpJal: begin
          r.next_pc = {pc4[31:28], w[25:0], 2'b00};
          wr = 1; r.reg_index = 5'd31; r.reg_value = pc4;
        end
        mie_pkg::OpBeq: if (a == b) r.next_pc = pc4 + (se << 2);
        mie_pkg::OpBne: if (a != b) r.next_pc = pc4 + (se << 2);
        mie_pkg::OpAddiu: begin wr = 1; r.reg_index = rt; r.reg_value = a + se; end
        mie_pkg::OpSlti: begin
          wr = 1; r.reg_index = rt; r.reg_value = {31'h0, $signed(a) < $signed(se)};
        end
        mie_pkg::OpSltiu: begin wr = 1; r.reg_index = rt; r.reg_value = {31'h0, a < se}; end
        mie_pkg::OpAndi: begin wr = 1; r.reg_index = rt; r.reg_value = a & zi; end
        mie_pkg::OpOri: begin wr = 1; r.reg_index = rt; r.reg_value = a | zi; end
        mie_pkg::OpXori: begin wr = 1; r.reg_index = rt; r.reg_value = a ^ zi; end
        mie_pkg::OpLui: begin wr = 1; r.reg_index = rt; r.reg_value = {w[15:0], 16'h0}; end
        mie_pkg::OpLb: begin mem_op = 1; r.mem_size = mie_pkg::SzByte; sign_ld = 1; end
        mie_pkg::OpLh: begin mem_op = 1; r.mem_size = mie_pkg::SzHalf; sign_ld = 1; end
        mie_pkg::OpLw: begin mem_op = 1; r.mem_size = mie_pkg::SzWord; end
        mie_pkg::OpLbu: begin mem_op = 1; r.mem_size = mie_pkg::SzByte; end
        mie_pkg::OpLhu: begin mem_op = 1; r.mem_size = mie_pkg::SzHalf; end
        mie_pkg::OpSb: begin mem_op = 1; r.mem_size = mie_pkg::SzByte; is_store = 1; end
        mie_pkg::OpSh: begin mem_op = 1; r.mem_size = mie_pkg::SzHalf; is_store = 1; end
        mie_pkg::OpSw: begin mem_op = 1; r.mem_size = mie_pkg::SzWord; is_store = 1; end
        default: r.status = mie_pkg::StIllegal;
      endcase
      if (mem_op) begin
        n = (r.mem_size == mie_pkg::SzByte) ? 1 : (r.mem_size == mie_pkg::SzHalf) ? 2 : 4;
        mask = (n == 4) ? 32'hffff_ffff : ((32'h1 << (8 * n)) - 1);
        r.mem_address = a + se;
        if (is_store) r.mem_value = b & mask;
        if (r.mem_address == 0 || (r.mem_address % n) != 0 ||
            64'(r.mem_address) + n > 64'(mie_pkg::MemBytes)) begin
          r.status = mie_pkg::StBadAddr;
        end else if (is_store) begin
          for (int i = 0; i < n; i++) mem[r.mem_address + i] = b[8*i +: 8];
          r.mem_written = 1;
        end else begin
          v = '0;
          for (int i = 0; i < n; i++) v[8*i +: 8] = rd_byte(r.mem_address + i);
          if (sign_ld && n == 1) v = {{24{v[7]}}, v[7:0]};
          if (sign_ld && n == 2) v = {{16{v[15]}}, v[15:0]};
          wr = 1; r.reg_index = rt; r.reg_value = v;
        end
      end
    end
    if (r.status == mie_pkg::StIllegal) begin
      r = '0; r.next_pc = pc; r.status = mie_pkg::StIllegal; wr = 0;
    end else if (r.status == mie_pkg::StBadAddr) begin
      r.next_pc = pc; wr = 0; r.mem_written = 0;
    end else begin
      if (wr && r.reg_index != 0) regs[r.reg_index] = r.reg_value;
      else wr = 0;
      pc = r.next_pc;
    end
    r.reg_written = wr;
    if (!wr) begin r.reg_index = '0; r.reg_value = '0; end
    pending.push_back(r);
  endfunction

  function void check_result(mie_pkg::result_t got);
    mie_pkg::result_t exp;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: expected pc %h rw %b ri %0d rv %h mw %b ma %h mv %h sz %0d st %0d",
                 exp.next_pc, exp.reg_written, exp.reg_index, exp.reg_value,
                 exp.mem_written, exp.mem_address, exp.mem_value, exp.mem_size, exp.status);
        $display("          actual   pc %h rw %b ri %0d rv %h mw %b ma %h mv %h sz %0d st %0d",
                 got.next_pc, got.reg_written, got.reg_index, got.reg_value,
                 got.mem_written, got.mem_address, got.mem_value, got.mem_size, got.status);
      end
    end
  endfunction
endclass

module tb_top;
  logic clk_i = 0;
  logic rst_ni = 0;
  logic instr_valid_i = 0;
  logic [31:0] instr_word_i = '0;
  logic res_stall_i = 1;
  logic instr_stall_o, res_valid_o, reg_written_o, mem_written_o;
  logic [31:0] next_pc_o, reg_value_o, mem_address_o, mem_value_o;
  logic [4:0] reg_index_o;
  logic [1:0] mem_size_o, status_o;
  mips_scoreboard sb;
  bit no_gaps;
  longint cycles;

  always #5 clk_i = ~clk_i;

  mips_instruction_executor DUT (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i)
      sb.check_result({next_pc_o, reg_written_o, reg_index_o, reg_value_o, mem_written_o,
                       mem_address_o, mem_value_o, mem_size_o, status_o});
  end

  // result-side stall pattern
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = no_gaps ? 0 : $urandom_range(0, 13);
      if (w == 0) res_stall_i <= 0;
      else begin
        res_stall_i <= 1;
        repeat (w) @(negedge clk_i);
        res_stall_i <= 0;
      end
      do @(posedge clk_i); while (!res_valid_o || res_stall_i);
    end
  end

  task automatic send(logic [31:0] w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      instr_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    instr_valid_i <= 1;
    instr_word_i <= w;
    do @(posedge clk_i); while (instr_stall_o);
    sb.note_request(w);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sh, logic [5:0] fn);
    return {mie_pkg::OpSpecial, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [5:0] ops [21] = '{mie_pkg::OpJ, mie_pkg::OpJal, mie_pkg::OpBeq, mie_pkg::OpBne,
      mie_pkg::OpAddiu, mie_pkg::OpSlti, mie_pkg::OpSltiu, mie_pkg::OpAndi, mie_pkg::OpOri,
      mie_pkg::OpXori, mie_pkg::OpLui, mie_pkg::OpLb, mie_pkg::OpLh, mie_pkg::OpLw,
      mie_pkg::OpLbu, mie_pkg::OpLhu, mie_pkg::OpSb, mie_pkg::OpSh, mie_pkg::OpSw,
      mie_pkg::OpSpecial, mie_pkg::OpSpecial};
    logic [5:0] fns [18] = '{mie_pkg::FnSll, mie_pkg::FnSrl, mie_pkg::FnSra, mie_pkg::FnJr,
      mie_pkg::FnJalr, mie_pkg::FnSyscall, mie_pkg::FnMfhi, mie_pkg::FnMflo, mie_pkg::FnMult,
      mie_pkg::FnMultu, mie_pkg::FnAddu, mie_pkg::FnSubu, mie_pkg::FnAnd, mie_pkg::FnOr,
      mie_pkg::FnXor, mie_pkg::FnNor, mie_pkg::FnSlt, mie_pkg::FnSltu};
    logic [31:0] w;
    logic [5:0] op;
    int k;
    k = $urandom_range(0, 99);
    w = $urandom();
    if (k < 4) return w;
    op = ops[$urandom_range(0, 20)];
    w[31:26] = op;
    if (op == mie_pkg::OpSpecial) w[5:0] = fns[$urandom_range(0, 17)];
    // memory ops mostly through base r1, kept pointing into memory
    if (op >= mie_pkg::OpLb && k < 85) begin
      w[25:21] = 5'd1;
      w[15:0] = ($urandom_range(0, 1) ? 16'h0 : 16'hffff) | 16'($urandom_range(0, 63));
      if ($urandom_range(0, 3) == 0) w[15:0] = 16'($urandom_range(0, 63)) - 16'd32;
    end
    if (op == mie_pkg::OpOri && k < 15) begin w[25:21] = 5'd0; w[20:16] = 5'd1; end
    if ((op == mie_pkg::OpBeq || op == mie_pkg::OpBne) && k < 50) w[25:16] = {w[20:16], w[20:16]};
    return w;
  endfunction

  initial begin
    sb = new();
    no_gaps = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // directed
    send(i_type(mie_pkg::OpOri, 5'd0, 5'd1, 16'h0100));
    send(i_type(mie_pkg::OpLui, 5'd0, 5'd2, 16'hffff));
    send(i_type(mie_pkg::OpOri, 5'd2, 5'd2, 16'hffff));
    send(i_type(mie_pkg::OpAddiu, 5'd0, 5'd3, 16'h8000));
    send(i_type(mie_pkg::OpAddiu, 5'd0, 5'd0, 16'h1234));
    send(r_type(5'd2, 5'd3, 5'd4, 5'd0, mie_pkg::FnMult));
    send(r_type(5'd0, 5'd0, 5'd5, 5'd0, mie_pkg::FnMfhi));
    send(r_type(5'd2, 5'd3, 5'd4, 5'd0, mie_pkg::FnMultu));
    send(r_type(5'd0, 5'd0, 5'd5, 5'd0, mie_pkg::FnMflo));
    send(r_type(5'd0, 5'd0, 5'd6, 5'd0, mie_pkg::FnMfhi));
    send(r_type(5'd0, 5'd3, 5'd7, 5'd31, mie_pkg::FnSra));
    send(r_type(5'd0, 5'd2, 5'd7, 5'd31, mie_pkg::FnSrl));
    send(i_type(mie_pkg::OpSw, 5'd1, 5'd2, 16'h0000));
    send(i_type(mie_pkg::OpLb, 5'd1, 5'd8, 16'h0003));
    send(i_type(mie_pkg::OpLhu, 5'd1, 5'd8, 16'h0002));
    send(i_type(mie_pkg::OpLw, 5'd1, 5'd8, 16'h0002));
    send(i_type(mie_pkg::OpSw, 5'd0, 5'd2, 16'h0000));
    send(i_type(mie_pkg::OpSb, 5'd2, 5'd2, 16'h0000));
    send(i_type(mie_pkg::OpLw, 5'd0, 5'd8, 16'h7ffc));
    send(32'hffff_ffff);
    send(r_type(5'd0, 5'd0, 5'd0, 5'd0, 6'h3f));
    send(r_type(5'd0, 5'd0, 5'd0, 5'd0, mie_pkg::FnSyscall));
    send(r_type(5'd1, 5'd0, 5'd9, 5'd0, mie_pkg::FnJalr));
    send({mie_pkg::OpJal, 26'h3ff_ffff});
    send(r_type(5'd2, 5'd0, 5'd0, 5'd0, mie_pkg::FnJr));
    // random
    for (int i = 0; i < 1600; i++) begin
      if (i % 400 == 0) no_gaps = (i % 800 == 0);
      if (i % 20 == 0) send(i_type(mie_pkg::OpOri, 5'd0, 5'd1, 16'($urandom_range(0, 16'hfff0))));
      send(rand_instr());
    end
    no_gaps = 0;
    instr_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire

>>> sim.f
design/mie_pkg.sv
design/mie_mult.sv
design/mips_instruction_executor.sv
tb/sv/tb_top.sv
